// File: design/mmdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmdf_pkg
// Shared widths, constants and operation codes for the front distance block.
// ----------------------------------------------------------------------------
package mmdf_pkg;

  localparam int COORD_W          = 32;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int PROD_W           = 2 * DIFF_W;
  localparam int DIST_W           = 34;
  localparam int CNT_W            = 20;
  localparam int SUM_W            = 54;
  localparam int ROOT_W           = 33;
  localparam int FRONT_DEPTH_DEF  = 1024;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_EVAL   = 2'd2,
    OP_REPORT = 2'd3
  } op_t;

  typedef enum logic {
    KIND_POINT  = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

endpackage

// File: design/mmdf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmdf_store
// Front point memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mmdf_store #(
  parameter int FRONT_DEPTH = mmdf_pkg::FRONT_DEPTH_DEF,
  parameter int AW          = 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [mmdf_pkg::COORD_W-1:0] wr_x,
  input  logic [mmdf_pkg::COORD_W-1:0] wr_y,
  input  logic [AW-1:0]                rd_addr,
  output logic [mmdf_pkg::COORD_W-1:0] rd_x,
  output logic [mmdf_pkg::COORD_W-1:0] rd_y
);
  import mmdf_pkg::*;

  logic [COORD_W-1:0] mem_x [FRONT_DEPTH];
  logic [COORD_W-1:0] mem_y [FRONT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

endmodule

// File: design/mean_min_distance_to_front_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_min_distance_to_front_core
// Nearest front point distance per evaluated point, and mean distance report.
// Clear and load act in the idle state. Evaluate: each front entry is read,
// differenced, squared and compared via the shared squarer, then the root is
// found bit by bit. Report: one quotient bit per cycle; empty cases go to FIN.
// One item at a time; a result may wait in the output register.
// Reset (rst_n low, synchronous) empties the front and clears sum and count.
// ----------------------------------------------------------------------------
module mean_min_distance_to_front_core #(
  parameter int FRONT_DEPTH = mmdf_pkg::FRONT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // coord_x[31:0], coord_y[63:32]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // distance[33:0], points_seen[53:34], empty_flag[54]
  output logic        out_tuser   // kind[0]
);
  import mmdf_pkg::*;

  localparam int AW = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
  localparam int SW = $clog2(FRONT_DEPTH + 1) + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(FRONT_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DIF, S_MX, S_MY, S_CMP, S_SQM, S_SQC, S_DIV, S_FIN
  } state_t;

  state_t               state_r;
  op_t                  op_r;
  logic [COORD_W-1:0]   x_r, y_r;
  logic [SW-1:0]        size_r, idx_r;
  logic [SUM_W-1:0]     sum_r;
  logic [CNT_W-1:0]     tot_r;
  logic                 empty_r;
  logic [DIFF_W-1:0]    dx_r, dy_r;
  logic [PROD_W-1:0]    p_r, acc_r;
  logic [PROD_W-1:0]    best_r;
  logic [ROOT_W-1:0]    root_r;
  logic [5:0]           step_r;
  logic [CNT_W:0]       rem_r;
  logic [SUM_W-1:0]     quo_r;
  logic                 out_valid_r;
  logic [55:0]          out_data_r;
  logic                 out_user_r;

  logic [COORD_W-1:0]   fx, fy;
  logic                 in_xfer, wr_en;
  logic [DIFF_W-1:0]    dxs, dys, mul_a;
  logic [PROD_W-1:0]    sq, prod;
  logic [ROOT_W-1:0]    cand;
  logic [CNT_W:0]       trial;
  logic                 fit;
  logic [DIST_W-1:0]    res_dist;
  logic [CNT_W-1:0]     tot_new;
  logic                 cnt_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign wr_en      = in_xfer && (op_t'(in_tuser) == OP_LOAD) && (size_r < DEPTH_S);

  mmdf_store #(.FRONT_DEPTH(FRONT_DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (size_r[AW-1:0]),
    .wr_x    (in_tdata[31:0]),
    .wr_y    (in_tdata[63:32]),
    .rd_addr (idx_r[AW-1:0]),
    .rd_x    (fx),
    .rd_y    (fy)
  );

  always_comb begin
    dxs   = {x_r[COORD_W-1], x_r} - {fx[COORD_W-1], fx};
    dys   = {y_r[COORD_W-1], y_r} - {fy[COORD_W-1], fy};
    cand  = root_r | (ROOT_W'(1) << step_r);
    unique case (state_r)
      S_MX:    mul_a = dx_r;
      S_MY:    mul_a = dy_r;
      default: mul_a = cand;
    endcase
    prod  = mul_a * mul_a;
    sq    = acc_r + p_r;
    trial = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    fit   = (trial >= {1'b0, tot_r});
    if (op_r == OP_EVAL) begin
      res_dist = empty_r ? DIST_MAX : DIST_W'(root_r);
    end else begin
      res_dist = empty_r ? '0 : quo_r[DIST_W-1:0];
    end
    cnt_inc = (op_r == OP_EVAL) && (tot_r != CNT_MAX);
    tot_new = cnt_inc ? tot_r + 1'b1 : tot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      sum_r       <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r  <= op_t'(in_tuser);
            x_r   <= in_tdata[31:0];
            y_r   <= in_tdata[63:32];
            idx_r <= '0;
            unique case (op_t'(in_tuser))
              OP_CLEAR: begin
                size_r <= '0;
                sum_r  <= '0;
                tot_r  <= '0;
              end
              OP_LOAD: begin
                if (wr_en) size_r <= size_r + 1'b1;
              end
              OP_EVAL: begin
                empty_r <= (size_r == '0);
                state_r <= (size_r == '0) ? S_FIN : S_RD;
              end
              OP_REPORT: begin
                empty_r <= (tot_r == '0);
                quo_r   <= sum_r;
                rem_r   <= '0;
                step_r  <= 6'(SUM_W - 1);
                state_r <= (tot_r == '0) ? S_FIN : S_DIV;
              end
              default: ;
            endcase
          end
        end
        S_RD:  state_r <= S_DIF;
        S_DIF: begin
          dx_r    <= dxs[DIFF_W-1] ? (~dxs + 1'b1) : dxs;
          dy_r    <= dys[DIFF_W-1] ? (~dys + 1'b1) : dys;
          state_r <= S_MX;
        end
        S_MX: begin
          p_r     <= prod;
          state_r <= S_MY;
        end
        S_MY: begin
          acc_r   <= p_r;
          p_r     <= prod;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (idx_r == '0 || sq < best_r) best_r <= sq;
          idx_r <= idx_r + 1'b1;
          if (idx_r + 1'b1 == size_r) begin
            root_r  <= '0;
            step_r  <= 6'(ROOT_W - 1);
            state_r <= S_SQM;
          end else begin
            state_r <= S_RD;
          end
        end
        S_SQM: begin
          p_r     <= prod;
          state_r <= S_SQC;
        end
        S_SQC: begin
          if (p_r <= best_r) root_r <= cand;
          if (step_r == '0) begin
            state_r <= S_FIN;
          end else begin
            step_r  <= step_r - 1'b1;
            state_r <= S_SQM;
          end
        end
        S_DIV: begin
          rem_r <= fit ? trial - {1'b0, tot_r} : trial;
          quo_r <= {quo_r[SUM_W-2:0], fit};
          if (step_r == '0) state_r <= S_FIN;
          else step_r <= step_r - 1'b1;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            if (cnt_inc) sum_r <= sum_r + SUM_W'(res_dist);
            tot_r       <= tot_new;
            out_valid_r <= 1'b1;
            out_user_r  <= (op_r == OP_EVAL) ? KIND_POINT : KIND_REPORT;
            out_data_r  <= {1'b0, empty_r, tot_new, res_dist};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= DEPTH_S) else $error("front size beyond depth");

  a_eval_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && op_t'(in_tuser) == OP_EVAL && size_r != '0) |=> state_r == S_RD)
    else $error("evaluate did not start scan");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (tot_r != $past(tot_r)) |-> (tot_r == '0 || tot_r == $past(tot_r) + 1'b1))
    else $error("point count jumped");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_tready) |=> state_r == S_FIN)
    else $error("result overwritten while output stalled");

endmodule
